### rtl/qspp_pkg.sv
// Shared types, codes, latencies and saturating helpers for the quadric
// surface point projection pipeline. No dependencies.
package qspp_pkg;

  typedef logic signed [63:0] sval_t;
  typedef logic [2:0][63:0] vec_t;

  typedef struct packed {
    logic [31:0]      idx;
    logic [2:0][31:0] pos;
    logic             lock;
  } item_t;

  localparam sval_t ILIM = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] ILIM65 = 65'sh0_3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] NLIM65 = -ILIM65;

  localparam logic [1:0] KIND_PLANE = 2'd0;
  localparam logic [1:0] KIND_CYL   = 2'd1;
  localparam logic [1:0] KIND_SPH   = 2'd2;
  localparam logic [1:0] KIND_TOR   = 2'd3;

  localparam logic [1:0] ST_PROJ  = 2'd0;
  localparam logic [1:0] ST_LOCK  = 2'd1;
  localparam logic [1:0] ST_DEGEN = 2'd2;

  localparam logic [2:0] REG_KIND   = 3'd0;
  localparam logic [2:0] REG_ORG_X  = 3'd1;
  localparam logic [2:0] REG_ORG_Y  = 3'd2;
  localparam logic [2:0] REG_ORG_Z  = 3'd3;
  localparam logic [2:0] REG_AXIS_X = 3'd4;
  localparam logic [2:0] REG_AXIS_Y = 3'd5;
  localparam logic [2:0] REG_AXIS_Z = 3'd6;
  localparam logic [2:0] REG_RADII  = 3'd7;

  localparam int MUL_LAT    = 3;
  localparam int SQRT_STEPS = 32;
  localparam int NORM_LAT   = 5 + SQRT_STEPS + 1;
  localparam int QBITS      = 62;
  localparam int DIV_LAT    = QBITS;
  localparam int REACH_LAT  = NORM_LAT + DIV_LAT + MUL_LAT + 1;
  localparam int AXIS_LAT   = 2 * MUL_LAT + 2;

  function automatic sval_t sat_add(sval_t a, sval_t b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > ILIM65) return ILIM;
    if (s < NLIM65) return -ILIM;
    return s[63:0];
  endfunction

  function automatic sval_t sat_sub(sval_t a, sval_t b);
    return sat_add(a, -b);
  endfunction

  function automatic sval_t ext32(logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

endpackage

### rtl/quadric_surface_point_projection.sv
// Projects mesh vertices onto a plane, cylinder, sphere or torus set up over
// the APB port; one transaction may enter every cycle while the output is not
// stalled. The depth comes from two reach units in series (32-stage square
// root, 62-stage divider each) behind the axis unit; a stall at the output
// freezes the whole pipeline.
// Depends on qspp_pkg, qspp_axis, qspp_reach, qspp_dly.
module quadric_surface_point_projection #(
  parameter int COORD_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // vertex_index, pos_x, pos_y, pos_z
  input  logic [0:0]   in_tuser,   // locked
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // out_index, out_x, out_y, out_z
  output logic [1:0]   out_tuser,  // status
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [5:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);
  import qspp_pkg::*;

  localparam int PIPE_LAT = 2 + AXIS_LAT + 1 + REACH_LAT + 1 + REACH_LAT;
  localparam logic [63:0] OUT_HI = (64'd1 << (COORD_WIDTH - 1)) - 64'd1;
  localparam logic [63:0] OUT_LO = ~OUT_HI;

  function automatic logic [31:0] sat_coord(sval_t x);
    if (x > $signed(OUT_HI)) return OUT_HI[31:0];
    if (x < $signed(OUT_LO)) return OUT_LO[31:0];
    return x[31:0];
  endfunction

  logic [1:0]       kind_r;
  logic [2:0][31:0] org_r, axis_r;
  logic [63:0]      radii_r;
  vec_t             o, n;

  logic                en;
  logic [PIPE_LAT-1:0] vld_r;
  item_t               item_r, item_a, item_b, item_c;
  vec_t                pa, pb, pc, p0;
  vec_t                a_r, c_r, w, wd;
  logic                neg_r;
  vec_t                vv1_r, base1_r, r1, r1d, vv2_r, base2_r, r2, res;
  logic [31:0]         rad1_r;
  logic                zero1, zero1d, zero2;
  logic [1:0]          st;
  logic                out_valid_r;
  logic [127:0]        out_tdata_r;
  logic [1:0]          out_tuser_r;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= KIND_PLANE;
      org_r   <= '0;
      axis_r  <= {32'h4000_0000, 32'd0, 32'd0};
      radii_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      case (cfg_paddr[5:3])
        REG_KIND:   kind_r    <= cfg_pwdata[1:0];
        REG_ORG_X:  org_r[0]  <= cfg_pwdata[31:0];
        REG_ORG_Y:  org_r[1]  <= cfg_pwdata[31:0];
        REG_ORG_Z:  org_r[2]  <= cfg_pwdata[31:0];
        REG_AXIS_X: axis_r[0] <= cfg_pwdata[31:0];
        REG_AXIS_Y: axis_r[1] <= cfg_pwdata[31:0];
        REG_AXIS_Z: axis_r[2] <= cfg_pwdata[31:0];
        REG_RADII:  radii_r   <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[5:3])
      REG_KIND:   cfg_prdata = {62'd0, kind_r};
      REG_ORG_X:  cfg_prdata = {32'd0, org_r[0]};
      REG_ORG_Y:  cfg_prdata = {32'd0, org_r[1]};
      REG_ORG_Z:  cfg_prdata = {32'd0, org_r[2]};
      REG_AXIS_X: cfg_prdata = {32'd0, axis_r[0]};
      REG_AXIS_Y: cfg_prdata = {32'd0, axis_r[1]};
      REG_AXIS_Z: cfg_prdata = {32'd0, axis_r[2]};
      REG_RADII:  cfg_prdata = radii_r;
      default:    cfg_prdata = '0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      o[i]  = ext32(org_r[i]);
      n[i]  = ext32(axis_r[i]);
      p0[i] = ext32(item_r.pos[i]);
      pa[i] = ext32(item_a.pos[i]);
      pb[i] = ext32(item_b.pos[i]);
      pc[i] = ext32(item_c.pos[i]);
    end
  end

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_LAT-2:0], in_tvalid};
    end
  end

  // input capture, then axis operands
  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= '{idx: in_tdata[31:0],
                  pos: {in_tdata[127:96], in_tdata[95:64], in_tdata[63:32]},
                  lock: in_tuser[0]};
      for (int i = 0; i < 3; i++) begin
        case (kind_r)
          KIND_PLANE: begin
            a_r[i] <= sat_sub(o[i], p0[i]);
            c_r[i] <= p0[i];
          end
          KIND_TOR: begin
            a_r[i] <= sat_sub(p0[i], o[i]);
            c_r[i] <= sat_sub(p0[i], o[i]);
          end
          default: begin
            a_r[i] <= sat_sub(p0[i], o[i]);
            c_r[i] <= o[i];
          end
        endcase
      end
      neg_r <= (kind_r == KIND_TOR);
    end
  end

  qspp_dly #(.W($bits(item_t)), .N(AXIS_LAT + 1)) u_ia (
    .clk(clk), .en(en), .d(item_r), .q(item_a)
  );

  qspp_axis u_axis (
    .clk(clk), .en(en), .a(a_r), .c(c_r), .n(n), .neg(neg_r), .w(w)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        case (kind_r)
          KIND_CYL: begin
            vv1_r[i]   <= sat_sub(pa[i], w[i]);
            base1_r[i] <= w[i];
          end
          KIND_TOR: begin
            vv1_r[i]   <= w[i];
            base1_r[i] <= o[i];
          end
          default: begin
            vv1_r[i]   <= sat_sub(pa[i], o[i]);
            base1_r[i] <= o[i];
          end
        endcase
      end
      rad1_r <= (kind_r == KIND_TOR) ? radii_r[63:32] : radii_r[31:0];
    end
  end

  qspp_reach u_reach1 (
    .clk(clk), .en(en), .base(base1_r), .v(vv1_r), .rad(rad1_r), .r(r1), .zero(zero1)
  );

  qspp_dly #(.W($bits(item_t)), .N(REACH_LAT + 1)) u_ib (
    .clk(clk), .en(en), .d(item_a), .q(item_b)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        vv2_r[i]   <= sat_sub(pb[i], r1[i]);
        base2_r[i] <= r1[i];
      end
    end
  end

  qspp_reach u_reach2 (
    .clk(clk), .en(en), .base(base2_r), .v(vv2_r), .rad(radii_r[31:0]),
    .r(r2), .zero(zero2)
  );

  qspp_dly #(.W($bits(item_t)), .N(REACH_LAT + 1)) u_ic (
    .clk(clk), .en(en), .d(item_b), .q(item_c)
  );
  qspp_dly #(.W(193), .N(REACH_LAT + 1)) u_r1d (
    .clk(clk), .en(en), .d({zero1, r1}), .q({zero1d, r1d})
  );
  qspp_dly #(.W(192), .N(2 * REACH_LAT + 2)) u_wd (
    .clk(clk), .en(en), .d(w), .q(wd)
  );

  always_comb begin
    if (item_c.lock) st = ST_LOCK;
    else if (kind_r == KIND_PLANE) st = ST_PROJ;
    else if (kind_r == KIND_TOR) st = (zero1d || zero2) ? ST_DEGEN : ST_PROJ;
    else st = zero1d ? ST_DEGEN : ST_PROJ;
    if (st != ST_PROJ) res = pc;
    else if (kind_r == KIND_PLANE) res = wd;
    else if (kind_r == KIND_TOR) res = r2;
    else res = r1d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[PIPE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= {sat_coord(res[2]), sat_coord(res[1]), sat_coord(res[0]), item_c.idx};
      out_tuser_r <= st;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_PROJ || out_tuser == ST_LOCK || out_tuser == ST_DEGEN))
    else $error("invalid status code on output");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline moved during stall");
endmodule

### rtl/qspp_dly.sv
// Enabled shift line used to align side data with the arithmetic stages.
// Depends on nothing.
module qspp_dly #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);
  logic [W-1:0] sh_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      sh_r[0] <= d;
      for (int i = 1; i < N; i++) sh_r[i] <= sh_r[i-1];
    end
  end

  assign q = sh_r[N-1];
endmodule

### rtl/qspp_mul30.sv
// Pipelined signed multiply by a Q.30 factor: partial products, sum with
// rounding, then scale/saturate. Depends on qspp_pkg.
module qspp_mul30 (
  input  logic            clk,
  input  logic            en,
  input  qspp_pkg::sval_t a,
  input  qspp_pkg::sval_t b,
  output qspp_pkg::sval_t q
);
  import qspp_pkg::*;

  logic [63:0]  ma, mb, qm;
  logic [63:0]  p00_r, p01_r, p10_r, p11_r;
  logic         neg1_r, neg2_r;
  logic [127:0] sum_r;
  sval_t        q_r;

  assign ma = a[63] ? (~a + 64'd1) : a;
  assign mb = b[63] ? (~b + 64'd1) : b;

  always_comb begin
    qm = (sum_r[127:94] != '0) ? ILIM : sum_r[93:30];
    if (qm > ILIM) qm = ILIM;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p00_r  <= ma[31:0]  * mb[31:0];
      p01_r  <= ma[31:0]  * mb[63:32];
      p10_r  <= ma[63:32] * mb[31:0];
      p11_r  <= ma[63:32] * mb[63:32];
      neg1_r <= a[63] ^ b[63];
      sum_r  <= 128'(p00_r) + (128'(p01_r) << 32) + (128'(p10_r) << 32)
              + {p11_r, 64'd0} + (128'd1 << 29);
      neg2_r <= neg1_r;
      q_r    <= neg2_r ? -qm : qm;
    end
  end

  assign q = q_r;
endmodule

### rtl/qspp_axis.sv
// Axis stage: w = c +/- n * dot(a, n), all in saturating fixed point.
// Depends on qspp_pkg, qspp_mul30, qspp_dly.
module qspp_axis (
  input  logic           clk,
  input  logic           en,
  input  qspp_pkg::vec_t a,
  input  qspp_pkg::vec_t c,
  input  qspp_pkg::vec_t n,
  input  logic           neg,
  output qspp_pkg::vec_t w
);
  import qspp_pkg::*;

  vec_t  m, u, cd, w_r;
  sval_t t_r;
  logic  negd;

  for (genvar i = 0; i < 3; i++) begin : g_mul
    qspp_mul30 u_dot (.clk(clk), .en(en), .a(a[i]), .b(n[i]), .q(m[i]));
    qspp_mul30 u_prj (.clk(clk), .en(en), .a(t_r), .b(n[i]), .q(u[i]));
  end

  qspp_dly #(.W(193), .N(2 * MUL_LAT + 1)) u_cdly (
    .clk(clk), .en(en), .d({neg, c}), .q({negd, cd})
  );

  always_ff @(posedge clk) begin
    if (en) begin
      t_r <= sat_add(sat_add(m[0], m[1]), m[2]);
      for (int i = 0; i < 3; i++) w_r[i] <= sat_add(cd[i], negd ? -u[i] : u[i]);
    end
  end

  assign w = w_r;
endmodule

### rtl/qspp_reach.sv
// Reach stage: r = base + v * (rad / |v|) with pipelined norm, square root
// and restoring divider. Depends on qspp_pkg, qspp_mul30, qspp_dly.
module qspp_reach (
  input  logic           clk,
  input  logic           en,
  input  qspp_pkg::vec_t base,
  input  qspp_pkg::vec_t v,
  input  logic [31:0]    rad,
  output qspp_pkg::vec_t r,
  output logic           zero
);
  import qspp_pkg::*;

  function automatic logic [61:0] mag62(sval_t x);
    return x[63] ? 62'(-x) : x[61:0];
  endfunction

  function automatic logic [4:0] norm_shift(logic [61:0] w);
    int bl;
    bl = 0;
    for (int i = 0; i < 62; i++) if (w[i]) bl = i + 1;
    return (bl > 31) ? 5'(bl - 31) : 5'd0;
  endfunction

  function automatic logic [127:0] sqrt_step(logic [63:0] x, logic [63:0] rr,
                                             logic [63:0] bitv);
    if (x >= rr + bitv) return {x - (rr + bitv), (rr >> 1) + bitv};
    return {x, rr >> 1};
  endfunction

  function automatic logic [63:0] div_step(logic [62:0] rem, logic nbit,
                                           logic [62:0] d);
    logic [63:0] remt, dd;
    remt = {rem, nbit};
    dd   = {1'b0, d};
    if (remt >= dd) return {1'b1, 63'(remt - dd)};
    return {1'b0, remt[62:0]};
  endfunction

  logic [61:0] m_r [3];
  logic [61:0] m2_r [3];
  logic [4:0]  k_r, kd;
  logic [30:0] t_r [3];
  logic [61:0] sq_r [3];
  logic [63:0] s_r;
  logic [63:0] sx_r [SQRT_STEPS], sr_r [SQRT_STEPS];
  logic [63:0] sx_nxt [SQRT_STEPS], sr_nxt [SQRT_STEPS];
  logic [62:0] len_r;
  logic [31:0] rad_d;
  logic [61:0] num;
  logic [62:0] dr_r [DIV_LAT], dd_r [DIV_LAT], dr_nxt [DIV_LAT];
  logic [61:0] dq_r [DIV_LAT], dn_r [DIV_LAT], dq_nxt [DIV_LAT];
  logic [63:0] stp [DIV_LAT];
  vec_t        vd, bd, mp, r_r;
  sval_t       lam;

  qspp_dly #(.W(5), .N(NORM_LAT - 3)) u_kdly (.clk(clk), .en(en), .d(k_r), .q(kd));
  qspp_dly #(.W(32), .N(NORM_LAT)) u_rdly (.clk(clk), .en(en), .d(rad), .q(rad_d));
  qspp_dly #(.W(192), .N(NORM_LAT + DIV_LAT)) u_vdly (
    .clk(clk), .en(en), .d(v), .q(vd)
  );
  qspp_dly #(.W(192), .N(NORM_LAT + DIV_LAT + MUL_LAT)) u_bdly (
    .clk(clk), .en(en), .d(base), .q(bd)
  );
  qspp_dly #(.W(1), .N(DIV_LAT + MUL_LAT + 1)) u_zdly (
    .clk(clk), .en(en), .d(len_r == '0), .q(zero)
  );

  assign num = {rad_d, 30'd0};

  always_comb begin
    {sx_nxt[0], sr_nxt[0]} = sqrt_step(s_r, 64'd0, 64'd1 << (2 * (SQRT_STEPS - 1)));
    for (int j = 1; j < SQRT_STEPS; j++)
      {sx_nxt[j], sr_nxt[j]} = sqrt_step(sx_r[j-1], sr_r[j-1],
                                         64'd1 << (2 * (SQRT_STEPS - 1 - j)));
  end

  always_comb begin
    stp[0]    = div_step(63'd0, num[QBITS-1], len_r);
    dr_nxt[0] = stp[0][62:0];
    dq_nxt[0] = {61'd0, stp[0][63]};
    for (int j = 1; j < DIV_LAT; j++) begin
      stp[j]    = div_step(dr_r[j-1], dn_r[j-1][QBITS-1-j], dd_r[j-1]);
      dr_nxt[j] = stp[j][62:0];
      dq_nxt[j] = {dq_r[j-1][QBITS-2:0], stp[j][63]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m_r[i]  <= mag62(v[i]);
        m2_r[i] <= m_r[i];
        t_r[i]  <= 31'(m2_r[i] >> k_r);
        sq_r[i] <= t_r[i] * t_r[i];
      end
      k_r <= norm_shift(m_r[0] | m_r[1] | m_r[2]);
      s_r <= 64'(sq_r[0]) + 64'(sq_r[1]) + 64'(sq_r[2]);
      for (int j = 0; j < SQRT_STEPS; j++) begin
        sx_r[j] <= sx_nxt[j];
        sr_r[j] <= sr_nxt[j];
      end
      len_r <= {31'd0, sr_r[SQRT_STEPS-1][31:0]} << kd;
      dd_r[0] <= len_r;
      dn_r[0] <= num;
      for (int j = 1; j < DIV_LAT; j++) begin
        dd_r[j] <= dd_r[j-1];
        dn_r[j] <= dn_r[j-1];
      end
      for (int j = 0; j < DIV_LAT; j++) begin
        dr_r[j] <= dr_nxt[j];
        dq_r[j] <= dq_nxt[j];
      end
      for (int i = 0; i < 3; i++) r_r[i] <= sat_add(bd[i], mp[i]);
    end
  end

  assign lam = {2'b00, dq_r[DIV_LAT-1]};

  for (genvar i = 0; i < 3; i++) begin : g_mul
    qspp_mul30 u_mul (.clk(clk), .en(en), .a(vd[i]), .b(lam), .q(mp[i]));
  end

  assign r = r_r;
endmodule
